>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the relation composition checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge outside of reset.
`define ASSERT_CLK_RST(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Checked at every rising edge, reset included.
`define ASSERT_CLK(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

>>> rtl/core/irsc_pkg.sv
// ----------------------------------------------------------------------------
// Interval relation set composition package
// Relation set type, bit codes and the Allen composition table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package irsc_pkg;

  localparam int RelCount = 13;

  typedef logic [RelCount-1:0] rel_set_t;

  localparam rel_set_t EQ = rel_set_t'(13'h0001);
  localparam rel_set_t BF = rel_set_t'(13'h0002);
  localparam rel_set_t DU = rel_set_t'(13'h0004);
  localparam rel_set_t OV = rel_set_t'(13'h0008);
  localparam rel_set_t ME = rel_set_t'(13'h0010);
  localparam rel_set_t ST = rel_set_t'(13'h0020);
  localparam rel_set_t FN = rel_set_t'(13'h0040);
  localparam rel_set_t AF = rel_set_t'(13'h0080);
  localparam rel_set_t CO = rel_set_t'(13'h0100);
  localparam rel_set_t OB = rel_set_t'(13'h0200);
  localparam rel_set_t MB = rel_set_t'(13'h0400);
  localparam rel_set_t SB = rel_set_t'(13'h0800);
  localparam rel_set_t FB = rel_set_t'(13'h1000);
  localparam rel_set_t ALLR = rel_set_t'(13'h1FFF);

  localparam rel_set_t G_BOMDS = BF | OV | ME | DU | ST;
  localparam rel_set_t G_AOMDF = AF | OB | MB | DU | FN;
  localparam rel_set_t G_BOMCF = BF | OV | ME | CO | FB;
  localparam rel_set_t G_AOMCS = AF | OB | MB | CO | SB;
  localparam rel_set_t G_MID = OV | OB | DU | ST | FN | CO | SB | FB | EQ;
  localparam rel_set_t G_ODS = OV | DU | ST;
  localparam rel_set_t G_BOM = BF | OV | ME;
  localparam rel_set_t G_OCF = OV | CO | FB;
  localparam rel_set_t G_OCS = OB | CO | SB;
  localparam rel_set_t G_ODF = OB | DU | FN;
  localparam rel_set_t G_AOM = AF | OB | MB;
  localparam rel_set_t G_SSE = ST | SB | EQ;
  localparam rel_set_t G_FFE = FN | FB | EQ;

  // Row is the relation from A to B, column the relation from B to C.
  localparam rel_set_t COMPOSE_TABLE [RelCount][RelCount] = '{
    '{EQ, BF, DU, OV, ME, ST, FN, AF, CO, OB, MB, SB, FB},
    '{BF, BF, G_BOMDS, BF, BF, BF, G_BOMDS, ALLR, BF, G_BOMDS, G_BOMDS, BF, BF},
    '{DU, BF, DU, G_BOMDS, BF, DU, DU, AF, ALLR, G_AOMDF, AF, G_AOMDF, G_BOMDS},
    '{OV, BF, G_ODS, G_BOM, BF, OV, G_ODS, G_AOMCS, G_BOMCF, G_MID, G_OCS, G_OCF,
      G_BOM},
    '{ME, BF, G_ODS, BF, BF, ME, G_ODS, G_AOMCS, BF, G_ODS, G_FFE, ME, BF},
    '{ST, BF, DU, G_BOM, BF, ST, DU, AF, G_BOMCF, G_ODF, MB, G_SSE, G_BOM},
    '{FN, BF, DU, G_ODS, ME, DU, FN, AF, G_AOMCS, G_AOM, AF, G_AOM, G_FFE},
    '{AF, ALLR, G_AOMDF, G_AOMDF, G_AOMDF, G_AOMDF, AF, AF, AF, AF, AF, AF, AF},
    '{CO, G_BOMCF, G_MID, G_OCF, G_OCF, G_OCF, G_OCS, G_AOMCS, CO, G_OCS, G_OCS,
      CO, CO},
    '{OB, G_BOMCF, G_ODF, G_MID, G_OCF, G_ODF, OB, AF, G_AOMCS, G_AOM, AF, G_AOM,
      G_OCS},
    '{MB, G_BOMCF, G_ODF, G_ODF, G_SSE, G_ODF, MB, AF, AF, AF, AF, AF, MB},
    '{SB, G_BOMCF, G_ODF, G_OCF, G_OCF, G_SSE, OB, AF, CO, OB, MB, SB, CO},
    '{FB, BF, G_ODS, OV, ME, OV, G_FFE, G_AOMCS, CO, G_OCS, G_OCS, CO, FB}
  };

endpackage

>>> rtl/core/irsc_chan_if.sv
// ----------------------------------------------------------------------------
// Interval relation set composition channels
// Valid/ready channels for the pair of input sets and the composed set.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface irsc_in_if import irsc_pkg::*;;
  logic     valid;
  logic     ready;
  rel_set_t first_set;
  rel_set_t second_set;

  modport source (output valid, output first_set, output second_set, input ready);
  modport sink (input valid, input first_set, input second_set, output ready);
endinterface

interface irsc_out_if import irsc_pkg::*;;
  logic     valid;
  logic     ready;
  rel_set_t composed_set;

  modport source (output valid, output composed_set, input ready);
  modport sink (input valid, input composed_set, output ready);
endinterface

>>> rtl/core/interval_relation_set_compose.sv
// An accepted input beat passes through the input register and then the result register.
// Throughput: one beat per cycle while out_ch.ready is high; the input register and the result register
// each advance whenever the stage after them is empty or drained.
// A full result register does not block the input while the input register is free.
// Reset (rst_n low, synchronous) empties both stages; no result is pending after it.
// ----------------------------------------------------------------------------
// Interval relation set composition
// Composes two sets of Allen interval relations through the composition table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module interval_relation_set_compose import irsc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  irsc_in_if.sink    in_ch,
  irsc_out_if.source out_ch
);

  logic     in_valid_r;
  rel_set_t first_r;
  rel_set_t second_r;
  logic     out_valid_r;
  rel_set_t composed_r;
  rel_set_t composed_nxt;
  logic     in_stage_ready;
  logic     out_stage_ready;

  assign out_stage_ready = !out_valid_r || out_ch.ready;
  assign in_stage_ready  = !in_valid_r || out_stage_ready;

  // Every table entry for a set pair of bits is ORed in; an empty set yields zero.
  always_comb begin
    composed_nxt = '0;
    for (int r = 0; r < RelCount; r++) begin
      for (int c = 0; c < RelCount; c++) begin
        if (first_r[r] && second_r[c]) begin
          composed_nxt = composed_nxt | COMPOSE_TABLE[r][c];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_stage_ready) begin
        in_valid_r <= in_ch.valid;
      end
      if (out_stage_ready) begin
        out_valid_r <= in_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_stage_ready) begin
      first_r  <= in_ch.first_set;
      second_r <= in_ch.second_set;
    end
    if (in_valid_r && out_stage_ready) begin
      composed_r <= composed_nxt;
    end
  end

  assign in_ch.ready         = in_stage_ready;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.composed_set = composed_r;

endmodule

>>> rtl/core/irsc_checker.sv
// ----------------------------------------------------------------------------
// Interval relation set composition checker
// Port-level checks on reset, latency, back-pressure and result holding.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module irsc_checker import irsc_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_ready,
  input logic     out_valid,
  input logic     out_ready,
  input rel_set_t composed_set
);

  `ASSERT_CLK(a_reset_empties, clk, !rst_n |=> !out_valid)
  `ASSERT_CLK_RST(a_ready_when_drained, clk, rst_n, !out_valid |-> in_ready)
  `ASSERT_CLK_RST(a_two_cycle_latency, clk, rst_n, in_valid && in_ready ##1 out_ready |=> out_valid)
  `ASSERT_CLK_RST(a_stall_holds, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(composed_set))

endmodule

bind interval_relation_set_compose irsc_checker u_irsc_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .composed_set (out_ch.composed_set)
);
